FILE: rtl/core/mie_pkg.sv
package mie_pkg;

   // I-format opcodes handled by the execute unit
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI  = 6'h0A;
   localparam logic [5:0] OP_ANDI  = 6'h0C;
   localparam logic [5:0] OP_ORI   = 6'h0D;
   localparam logic [5:0] OP_XORI  = 6'h0E;
   localparam logic [5:0] OP_LUI   = 6'h0F;
   localparam logic [5:0] OP_LB    = 6'h20;
   localparam logic [5:0] OP_LH    = 6'h21;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SB    = 6'h28;
   localparam logic [5:0] OP_SH    = 6'h29;
   localparam logic [5:0] OP_SW    = 6'h2B;

   // access sizes in bytes
   localparam logic [2:0] SIZE_NONE = 3'd0;
   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;

   localparam logic [31:0] DATA_BASE_RESET = 32'h1001_0000;

   // data memory is four byte-wide banks, one per byte lane
   localparam int NUM_BANKS = 4;

   typedef struct packed {
      logic                 rd;
      logic                 wr;
      logic [NUM_BANKS-1:0] be;
   } mie_mem_ctl_type;

endpackage

FILE: rtl/core/mie_regfile.sv
module mie_regfile
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b
);

   logic [31:0] rf_ff [32];
   logic [31:0] vld_ff;
   logic [31:0] q_a_ff;
   logic [31:0] q_b_ff;
   logic        q_a_vld_ff;
   logic        q_b_vld_ff;

   // entries never written read as zero; entry 0 is never marked valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         q_a_vld_ff <= 1'b0;
         q_b_vld_ff <= 1'b0;
      end else begin
         if (wr_en && (wr_addr != 5'd0)) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_a_vld_ff <= vld_ff[rd_addr_a];
            q_b_vld_ff <= vld_ff[rd_addr_b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr != 5'd0)) begin
         rf_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_a_ff <= rf_ff[rd_addr_a];
         q_b_ff <= rf_ff[rd_addr_b];
      end
   end

   assign rd_data_a = q_a_vld_ff ? q_a_ff : 32'd0;
   assign rd_data_b = q_b_vld_ff ? q_b_ff : 32'd0;

endmodule

FILE: rtl/core/mie_dmem.sv
module mie_dmem
   import mie_pkg::*;
#(
   parameter int MEM_BYTES = 4096
)
(
   input  logic                                         clock,
   input  logic                                         reset,
   input  mie_mem_ctl_type                              mem_ctl,
   input  logic [NUM_BANKS-1:0][$clog2(MEM_BYTES)-3:0] mem_row,
   input  logic [NUM_BANKS-1:0][7:0]                    mem_wdata,
   output logic [NUM_BANKS-1:0][7:0]                    mem_rdata,
   output logic                                         clr_busy
);

   localparam int ROW_W = $clog2(MEM_BYTES) - 2;
   localparam int ROWS  = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic [ROW_W-1:0] clr_row_ff;
   logic             clr_busy_ff;

   // zeroing sweep after reset, one row of all banks per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_row_ff <= clr_row_ff + ROW_W'(1);
         if (clr_row_ff == LAST_ROW) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign clr_busy = clr_busy_ff;

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      logic [7:0]       bank_ff [ROWS];
      logic [7:0]       q_ff;
      logic [ROW_W-1:0] row;
      logic             wen;
      logic [7:0]       wdat;

      assign row  = clr_busy_ff ? clr_row_ff : mem_row[g];
      assign wen  = clr_busy_ff || (mem_ctl.wr && mem_ctl.be[g]);
      assign wdat = clr_busy_ff ? 8'd0 : mem_wdata[g];

      always_ff @(posedge clock) begin
         if (wen) begin
            bank_ff[row] <= wdat;
         end
         if (mem_ctl.rd) begin
            q_ff <= bank_ff[row];
         end
      end

      assign mem_rdata[g] = q_ff;
   end

endmodule

FILE: rtl/core/mips_itype_execute.sv
// MIPS32 I-format execute unit with its own register file and data memory.
// Request channel (req_valid/req_ready) carries one instruction word and its
// pc per transaction; response channel (rsp_valid/rsp_ready) returns one
// result per instruction, in order. csr_wr_en/csr_wr_data write the data
// base address (byte address of data memory offset 0) with no handshake;
// write it only while no transaction is in flight.
// Pipeline: issue (register file read) -> execute (ALU, branch, address,
// store write / load read of the four byte banks) -> writeback (load
// alignment, register write) -> response register. One transaction per
// cycle is sustained while the receiver does not stall, including dependent
// back-to-back instructions and load-use pairs, which are served by
// forwarding from writeback and from the last register write.
// Reset clears the register file (valid bits) at once and then zeroes the
// data memory, one 4-byte row per cycle, with req_ready low until it is
// done. Configuration writes are taken throughout. When the receiver
// stalls, the whole pipeline holds and req_ready drops in the same cycle;
// nothing is lost or repeated.
module mips_itype_execute
   import mie_pkg::*;
#(
   parameter int MEM_BYTES = 4096
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr,
   input  logic [31:0] req_cur_pc,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_reg,
   output logic [31:0] rsp_write_value,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_overflow,
   output logic        rsp_address_error,
   output logic        rsp_unknown_opcode,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int ROW_W  = ADDR_W - 2;
   localparam logic [31:0] MEM_SIZE = 32'(MEM_BYTES);

   // ---------------------------------------------------------------------
   // Control: the pipeline advances as a whole whenever the response
   // register is free or being drained.
   // ---------------------------------------------------------------------
   logic adv;
   logic clr_busy;
   logic req_accept;

   logic        rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_ready;
   assign req_ready  = adv && !clr_busy;
   assign req_accept = req_valid && req_ready;

   // data base address register
   logic [31:0] base_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= DATA_BASE_RESET;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Issue -> execute register; register file is read at the same edge
   // ---------------------------------------------------------------------
   logic        s1_vld_ff;
   logic [31:0] s1_instr_ff;
   logic [31:0] s1_pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_instr_ff <= req_instr;
         s1_pc_ff    <= req_cur_pc;
      end
   end

   logic [31:0] rf_a;
   logic [31:0] rf_b;
   logic        rf_we;
   logic [4:0]  s2_rt_ff;
   logic [31:0] s2_value;

   mie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (adv),
      .rd_addr_a (req_instr[25:21]),
      .rd_addr_b (req_instr[20:16]),
      .wr_en     (rf_we),
      .wr_addr   (s2_rt_ff),
      .wr_data   (s2_value),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // Last register write, taken at the edge the execute-stage item read
   // the file (read-before-write there, so it is forwarded from here).
   logic        lw_vld_ff;
   logic [4:0]  lw_rt_ff;
   logic [31:0] lw_data_ff;

   // ---------------------------------------------------------------------
   // Execute stage
   // ---------------------------------------------------------------------
   logic [5:0]  s1_op;
   logic [4:0]  s1_rs;
   logic [4:0]  s1_rt;
   logic [15:0] s1_zimm;
   logic [31:0] s1_simm;
   logic [31:0] s1_zext;
   logic [31:0] s1_a;
   logic [31:0] s1_b;
   logic [31:0] s1_sum;
   logic [31:0] s1_off;
   logic [31:0] s1_lim;
   logic [31:0] s1_st_val;
   logic        s1_is_load;
   logic        s1_is_store;
   logic [2:0]  s1_size;
   logic        s1_aerr;

   logic        s2_vld_ff;
   logic        s2_wr_ff;
   logic        s2_load_ff;
   logic        s2_wb_ff;

   // writeback forwarding
   logic        s2_fwd;
   assign s2_fwd = s2_vld_ff && s2_wb_ff;

   assign s1_op   = s1_instr_ff[31:26];
   assign s1_rs   = s1_instr_ff[25:21];
   assign s1_rt   = s1_instr_ff[20:16];
   assign s1_zimm = s1_instr_ff[15:0];
   assign s1_simm = {{16{s1_zimm[15]}}, s1_zimm};
   assign s1_zext = {16'd0, s1_zimm};

   always_comb begin
      if (s2_fwd && (s2_rt_ff == s1_rs)) begin
         s1_a = s2_value;
      end else if (lw_vld_ff && (lw_rt_ff == s1_rs)) begin
         s1_a = lw_data_ff;
      end else begin
         s1_a = rf_a;
      end
      if (s2_fwd && (s2_rt_ff == s1_rt)) begin
         s1_b = s2_value;
      end else if (lw_vld_ff && (lw_rt_ff == s1_rt)) begin
         s1_b = lw_data_ff;
      end else begin
         s1_b = rf_b;
      end
   end

   // load/store decode: kind and size of the access
   always_comb begin
      s1_is_load  = 1'b0;
      s1_is_store = 1'b0;
      s1_size     = SIZE_NONE;
      case (s1_op)
         OP_LW: begin
            s1_is_load = 1'b1;
            s1_size    = SIZE_WORD;
         end
         OP_LH: begin
            s1_is_load = 1'b1;
            s1_size    = SIZE_HALF;
         end
         OP_LB: begin
            s1_is_load = 1'b1;
            s1_size    = SIZE_BYTE;
         end
         OP_SW: begin
            s1_is_store = 1'b1;
            s1_size     = SIZE_WORD;
         end
         OP_SH: begin
            s1_is_store = 1'b1;
            s1_size     = SIZE_HALF;
         end
         OP_SB: begin
            s1_is_store = 1'b1;
            s1_size     = SIZE_BYTE;
         end
         default: begin
            s1_size = SIZE_NONE;
         end
      endcase
   end

   assign s1_sum = s1_a + s1_simm;
   assign s1_off = s1_sum - base_ff;
   assign s1_lim = MEM_SIZE - {29'd0, s1_size};
   // every byte must land inside memory; no wrap-around
   assign s1_aerr = (s1_is_load || s1_is_store) && (s1_off > s1_lim);

   always_comb begin
      case (s1_size)
         SIZE_WORD: s1_st_val = s1_b;
         SIZE_HALF: s1_st_val = {16'd0, s1_b[15:0]};
         default:   s1_st_val = {24'd0, s1_b[7:0]};
      endcase
   end

   // next values of the writeback register
   logic        s2_wr_in;
   logic [31:0] s2_val_in;
   logic        s2_taken_in;
   logic [31:0] s2_npc_in;
   logic        s2_ovf_in;
   logic        s2_unk_in;

   always_comb begin
      s2_wr_in    = 1'b0;
      s2_val_in   = 32'd0;
      s2_taken_in = 1'b0;
      s2_ovf_in   = 1'b0;
      s2_unk_in   = 1'b0;
      case (s1_op)
         OP_ADDI: begin
            if (((s1_a ^ s1_sum) & (s1_simm ^ s1_sum) & 32'h8000_0000) != 32'd0) begin
               s2_ovf_in = 1'b1;
            end else begin
               s2_val_in = s1_sum;
               s2_wr_in  = 1'b1;
            end
         end
         OP_ADDIU: begin
            s2_val_in = s1_sum;
            s2_wr_in  = 1'b1;
         end
         OP_ANDI: begin
            s2_val_in = s1_a & s1_zext;
            s2_wr_in  = 1'b1;
         end
         OP_ORI: begin
            s2_val_in = s1_a | s1_zext;
            s2_wr_in  = 1'b1;
         end
         OP_XORI: begin
            s2_val_in = s1_a ^ s1_zext;
            s2_wr_in  = 1'b1;
         end
         OP_SLTI: begin
            s2_val_in = {31'd0, $signed(s1_a) < $signed(s1_simm)};
            s2_wr_in  = 1'b1;
         end
         OP_LUI: begin
            s2_val_in = {s1_zimm, 16'd0};
            s2_wr_in  = 1'b1;
         end
         OP_BEQ: begin
            s2_taken_in = (s1_a == s1_b);
         end
         OP_BNE: begin
            s2_taken_in = (s1_a != s1_b);
         end
         // loads and stores: handled below
         OP_LW, OP_LH, OP_LB, OP_SW, OP_SH, OP_SB: begin
            s2_unk_in = 1'b0;
         end
         default: begin
            s2_unk_in = 1'b1;
         end
      endcase
      if (s1_is_store && !s1_aerr) begin
         s2_val_in = s1_st_val;
      end
      if (s1_is_load && !s1_aerr) begin
         s2_wr_in = 1'b1;
      end
   end

   assign s2_npc_in = s2_taken_in ? (s1_pc_ff + s1_simm) : s1_pc_ff;

   // Byte lanes: lane g holds offsets with offset[1:0] == g. An access of
   // up to four bytes touches each lane at most once, so all lanes go in
   // the same cycle, each at its own row.
   logic [NUM_BANKS-1:0][1:0]        bank_sel;
   logic [NUM_BANKS-1:0][ADDR_W-1:0] bank_addr;
   logic [NUM_BANKS-1:0][ROW_W-1:0]  bank_row;
   logic [NUM_BANKS-1:0][7:0]        bank_wdata;
   logic [NUM_BANKS-1:0][7:0]        bank_rdata;
   mie_mem_ctl_type                  mem_ctl;

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_lane
      assign bank_sel[g]   = 2'(g) - s1_off[1:0];
      assign bank_addr[g]  = s1_off[ADDR_W-1:0] + ADDR_W'(bank_sel[g]);
      assign bank_row[g]   = bank_addr[g][ADDR_W-1:2];
      assign bank_wdata[g] = s1_st_val[{bank_sel[g], 3'b000} +: 8];
      assign mem_ctl.be[g] = ({1'b0, bank_sel[g]} < s1_size);
   end

   // stores write and loads read at the edge the item leaves execute,
   // so a following load always sees the stored bytes
   assign mem_ctl.rd = adv && s1_vld_ff && s1_is_load && !s1_aerr;
   assign mem_ctl.wr = adv && s1_vld_ff && s1_is_store && !s1_aerr;

   mie_dmem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_dmem (
      .clock     (clock),
      .reset     (reset),
      .mem_ctl   (mem_ctl),
      .mem_row   (bank_row),
      .mem_wdata (bank_wdata),
      .mem_rdata (bank_rdata),
      .clr_busy  (clr_busy)
   );

   // ---------------------------------------------------------------------
   // Writeback stage
   // ---------------------------------------------------------------------
   logic [31:0] s2_val_ff;
   logic [2:0]  s2_size_ff;
   logic [1:0]  s2_off_lo_ff;
   logic        s2_taken_ff;
   logic [31:0] s2_npc_ff;
   logic        s2_ovf_ff;
   logic        s2_aerr_ff;
   logic        s2_unk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_rt_ff     <= s1_rt;
         s2_wr_ff     <= s2_wr_in;
         s2_wb_ff     <= s2_wr_in && (s1_rt != 5'd0);
         s2_load_ff   <= s1_is_load && !s1_aerr;
         s2_val_ff    <= s2_val_in;
         s2_size_ff   <= s1_size;
         s2_off_lo_ff <= s1_off[1:0];
         s2_taken_ff  <= s2_taken_in;
         s2_npc_ff    <= s2_npc_in;
         s2_ovf_ff    <= s2_ovf_in;
         s2_aerr_ff   <= s1_aerr;
         s2_unk_ff    <= s2_unk_in;
      end
   end

   // load: gather lanes back into byte order, then sign-extend
   logic [31:0] s2_raw;
   logic [31:0] s2_ld_val;

   always_comb begin
      for (int i = 0; i < NUM_BANKS; i++) begin
         s2_raw[8*i +: 8] = bank_rdata[s2_off_lo_ff + 2'(i)];
      end
      case (s2_size_ff)
         SIZE_WORD: s2_ld_val = s2_raw;
         SIZE_HALF: s2_ld_val = {{16{s2_raw[15]}}, s2_raw[15:0]};
         default:   s2_ld_val = {{24{s2_raw[7]}}, s2_raw[7:0]};
      endcase
   end

   assign s2_value = s2_load_ff ? s2_ld_val : s2_val_ff;
   assign rf_we    = adv && s2_fwd;

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_vld_ff <= 1'b0;
      end else if (adv) begin
         lw_vld_ff <= s2_fwd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lw_rt_ff   <= s2_rt_ff;
         lw_data_ff <= s2_value;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic        rsp_reg_written_ff;
   logic [4:0]  rsp_dest_reg_ff;
   logic [31:0] rsp_write_value_ff;
   logic        rsp_branch_taken_ff;
   logic [31:0] rsp_next_pc_ff;
   logic        rsp_overflow_ff;
   logic        rsp_address_error_ff;
   logic        rsp_unknown_opcode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_reg_written_ff    <= s2_wb_ff;
         rsp_dest_reg_ff       <= s2_rt_ff;
         // value shown even when the target is register zero
         rsp_write_value_ff    <= s2_wr_ff ? s2_value : s2_val_ff;
         rsp_branch_taken_ff   <= s2_taken_ff;
         rsp_next_pc_ff        <= s2_npc_ff;
         rsp_overflow_ff       <= s2_ovf_ff;
         rsp_address_error_ff  <= s2_aerr_ff;
         rsp_unknown_opcode_ff <= s2_unk_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reg_written    = rsp_reg_written_ff;
   assign rsp_dest_reg       = rsp_dest_reg_ff;
   assign rsp_write_value    = rsp_write_value_ff;
   assign rsp_branch_taken   = rsp_branch_taken_ff;
   assign rsp_next_pc        = rsp_next_pc_ff;
   assign rsp_overflow       = rsp_overflow_ff;
   assign rsp_address_error  = rsp_address_error_ff;
   assign rsp_unknown_opcode = rsp_unknown_opcode_ff;

endmodule

FILE: sim/itype_result_checker.sv
module itype_result_checker
   import mie_pkg::*;
#(
   parameter int MEM_BYTES = 4096
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_instr,
   input  logic [31:0] req_cur_pc,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_reg_written,
   input  logic [4:0]  rsp_dest_reg,
   input  logic [31:0] rsp_write_value,
   input  logic        rsp_branch_taken,
   input  logic [31:0] rsp_next_pc,
   input  logic        rsp_overflow,
   input  logic        rsp_address_error,
   input  logic        rsp_unknown_opcode,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          mismatch_count,
   output int          outstanding
);

   typedef struct packed {
      logic        reg_written;
      logic [4:0]  dest_reg;
      logic [31:0] write_value;
      logic        branch_taken;
      logic [31:0] next_pc;
      logic        overflow;
      logic        address_error;
      logic        unknown_opcode;
   } itype_result_type;

   logic [31:0]      gpr [32];
   logic [7:0]       dmem [MEM_BYTES];
   logic [31:0]      dmem_base;
   itype_result_type awaited_results [$];
   int               error_total = 0;

   // executes one instruction against the shadow register file and memory
   function automatic itype_result_type execute_itype(input logic [31:0] word,
                                                      input logic [31:0] pc);
      logic [5:0]       op;
      logic [4:0]       rs, rt;
      logic [31:0]      zimm, simm, a, b, sum, offset, value;
      logic [2:0]       size;
      logic             is_load, is_store, wr;
      itype_result_type res;
      op       = word[31:26];
      rs       = word[25:21];
      rt       = word[20:16];
      zimm     = {16'h0000, word[15:0]};
      simm     = {{16{word[15]}}, word[15:0]};
      a        = gpr[rs];
      b        = gpr[rt];
      offset   = a + simm - dmem_base;
      res      = '0;
      res.dest_reg = rt;
      res.next_pc  = pc;
      size     = SIZE_NONE;
      is_load  = 1'b0;
      is_store = 1'b0;
      wr       = 1'b0;
      value    = '0;
      case (op)
         OP_ADDI: begin
            sum = a + simm;
            if (a[31] == simm[31] && sum[31] != a[31]) begin
               res.overflow = 1'b1;
            end else begin
               res.write_value = sum;
               wr = 1'b1;
            end
         end
         OP_ADDIU: begin res.write_value = a + simm; wr = 1'b1; end
         OP_ANDI:  begin res.write_value = a & zimm; wr = 1'b1; end
         OP_ORI:   begin res.write_value = a | zimm; wr = 1'b1; end
         OP_XORI:  begin res.write_value = a ^ zimm; wr = 1'b1; end
         OP_SLTI: begin
            res.write_value = {31'b0, $signed(a) < $signed(simm)};
            wr = 1'b1;
         end
         OP_LUI:   begin res.write_value = {word[15:0], 16'h0000}; wr = 1'b1; end
         OP_BEQ:   res.branch_taken = (a == b);
         OP_BNE:   res.branch_taken = (a != b);
         OP_LW:    begin is_load  = 1'b1; size = SIZE_WORD; end
         OP_LH:    begin is_load  = 1'b1; size = SIZE_HALF; end
         OP_LB:    begin is_load  = 1'b1; size = SIZE_BYTE; end
         OP_SW:    begin is_store = 1'b1; size = SIZE_WORD; end
         OP_SH:    begin is_store = 1'b1; size = SIZE_HALF; end
         OP_SB:    begin is_store = 1'b1; size = SIZE_BYTE; end
         default:  res.unknown_opcode = 1'b1;
      endcase
      if (is_load || is_store) begin
         if (({1'b0, offset} + 33'(size)) > 33'(MEM_BYTES)) begin
            res.address_error = 1'b1;
         end else if (is_load) begin
            for (int i = 0; i < int'(size); i++)
               value[8*i +: 8] = dmem[offset + i];
            if (size == SIZE_HALF) value = {{16{value[15]}}, value[15:0]};
            if (size == SIZE_BYTE) value = {{24{value[7]}}, value[7:0]};
            res.write_value = value;
            wr = 1'b1;
         end else begin
            value = b;
            if (size == SIZE_HALF) value = {16'h0000, b[15:0]};
            if (size == SIZE_BYTE) value = {24'h000000, b[7:0]};
            res.write_value = value;
            for (int i = 0; i < int'(size); i++)
               dmem[offset + i] = value[8*i +: 8];
         end
      end
      if (res.branch_taken) res.next_pc = pc + simm;
      if (wr && rt != 5'd0) begin
         gpr[rt] = res.write_value;
         res.reg_written = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      itype_result_type got, want;
      if (reset) begin
         dmem_base = DATA_BASE_RESET;
         foreach (gpr[i]) gpr[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) dmem_base = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_reg_written, rsp_dest_reg, rsp_write_value, rsp_branch_taken,
                    rsp_next_pc, rsp_overflow, rsp_address_error, rsp_unknown_opcode};
            if (awaited_results.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("unexpected transaction: %p", got);
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  error_total++;
                  if (error_total <= 10)
                     $display("mismatch: expected %p, actual %p", want, got);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(execute_itype(req_instr, req_cur_pc));
      end
      outstanding    <= awaited_results.size();
      mismatch_count <= error_total;
   end

endmodule

FILE: sim/mips_itype_execute_test.sv
module mips_itype_execute_test;
   import mie_pkg::*;

   localparam int MEM_BYTES        = 4096;
   localparam int RANDOM_PER_PHASE = 180;
   localparam int NUM_PHASES       = 6;
   localparam int LONG_HOLD        = 200;
   localparam int SETTLE_CYCLES    = 8;
   // reset clearing pass, ~1100 transactions with worst-case gaps on both sides,
   // two long hold-offs; then several times over
   localparam int CYCLE_LIMIT      = 200000;

   // named registers for the directed part; pointers live in PTR_FIRST..+3
   localparam logic [4:0] R_ZERO    = 5'd0;
   localparam logic [4:0] R_POS     = 5'd1;
   localparam logic [4:0] R_MAX     = 5'd2;
   localparam logic [4:0] R_OVF     = 5'd3;
   localparam logic [4:0] R_NEG     = 5'd4;
   localparam logic [4:0] R_MIN     = 5'd5;
   localparam logic [4:0] R_SUM     = 5'd6;
   localparam logic [4:0] R_AND     = 5'd7;
   localparam logic [4:0] R_XOR     = 5'd8;
   localparam logic [4:0] R_SLT     = 5'd9;
   localparam logic [4:0] R_PTR     = 5'd10;
   localparam logic [4:0] R_LB      = 5'd11;
   localparam logic [4:0] R_LH      = 5'd12;
   localparam logic [4:0] R_LW      = 5'd13;
   localparam int         PTR_FIRST = 20;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [31:0] req_instr   = '0;
   logic [31:0] req_cur_pc  = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_reg_written;
   logic [4:0]  rsp_dest_reg;
   logic [31:0] rsp_write_value;
   logic        rsp_branch_taken;
   logic [31:0] rsp_next_pc;
   logic        rsp_overflow;
   logic        rsp_address_error;
   logic        rsp_unknown_opcode;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int          mismatch_count;
   int          outstanding;

   // no idling on either side once this is set (last phase)
   logic        no_idling   = 1'b0;
   // current data base and byte offset each pointer register was set to
   logic [31:0] base_now    = DATA_BASE_RESET;
   int          ptr_off [4] = '{0, 0, 0, 0};
   int          stall_left  = 0;
   int          rsp_seen    = 0;

   always #1 clock = ~clock;

   mips_itype_execute #(.MEM_BYTES(MEM_BYTES)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_instr          (req_instr),
      .req_cur_pc         (req_cur_pc),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reg_written    (rsp_reg_written),
      .rsp_dest_reg       (rsp_dest_reg),
      .rsp_write_value    (rsp_write_value),
      .rsp_branch_taken   (rsp_branch_taken),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_overflow       (rsp_overflow),
      .rsp_address_error  (rsp_address_error),
      .rsp_unknown_opcode (rsp_unknown_opcode),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   itype_result_checker #(.MEM_BYTES(MEM_BYTES)) result_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_instr          (req_instr),
      .req_cur_pc         (req_cur_pc),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reg_written    (rsp_reg_written),
      .rsp_dest_reg       (rsp_dest_reg),
      .rsp_write_value    (rsp_write_value),
      .rsp_branch_taken   (rsp_branch_taken),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_overflow       (rsp_overflow),
      .rsp_address_error  (rsp_address_error),
      .rsp_unknown_opcode (rsp_unknown_opcode),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [5:0] pick_mem_op();
      case ($urandom_range(0, 5))
         0:       return OP_LB;
         1:       return OP_LH;
         2:       return OP_LW;
         3:       return OP_SB;
         4:       return OP_SH;
         default: return OP_SW;
      endcase
   endfunction

   function automatic logic [5:0] pick_alu_op();
      case ($urandom_range(0, 6))
         0:       return OP_ADDI;
         1:       return OP_ADDIU;
         2:       return OP_SLTI;
         3:       return OP_ANDI;
         4:       return OP_ORI;
         5:       return OP_XORI;
         default: return OP_LUI;
      endcase
   endfunction

   // extremes first (0 and all ones), then a base whose window wraps past the
   // top of the address space, a random one, the reset value and a high one
   function automatic logic [31:0] phase_base(input int ph);
      case (ph)
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'hFFFF_F800;
         3:       return $urandom();
         4:       return DATA_BASE_RESET;
         default: return 32'h7FFF_FFF0;
      endcase
   endfunction

   // one request transaction; valid stays high afterwards unless the next
   // call opens an idle burst, so it is never dropped and raised in one step
   task automatic offer(input logic [31:0] word, input logic [31:0] pc);
      if (!no_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_instr  <= word;
      req_cur_pc <= pc;
      do @(posedge clock); while (!req_ready);
   endtask

   // base register only changes once the pipe has drained; every transaction
   // yields a response, so an empty scoreboard means the block is idle
   task automatic write_base(input logic [31:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_now = value;
   endtask

   // loads a pointer register with an address inside the data window
   task automatic point_at(input int k);
      logic [31:0] addr;
      ptr_off[k] = $urandom_range(0, MEM_BYTES - 1);
      addr = base_now + ptr_off[k];
      offer(itype(OP_LUI, R_ZERO, 5'(PTR_FIRST + k), addr[31:16]), $urandom());
      offer(itype(OP_ORI, 5'(PTR_FIRST + k), 5'(PTR_FIRST + k), addr[15:0]), $urandom());
   endtask

   // mostly well-formed traffic: pointer set-ups, loads/stores around the
   // window edges, ALU ops and branches; a share of raw random words as noise
   task automatic random_phase(input int count);
      int          left, sel, k;
      logic [4:0]  rs, rt;
      logic [15:0] imm;
      left = count;
      while (left > 0) begin
         sel = $urandom_range(0, 99);
         k   = $urandom_range(0, 3);
         rs  = 5'($urandom_range(0, 31));
         rt  = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 19));
         imm = 16'($urandom());
         if (sel < 8) begin
            point_at(k);
            left -= 2;
         end else if (sel < 50) begin
            // offset lands a few bytes either side of the window
            if ($urandom_range(0, 9) != 0)
               imm = 16'($urandom_range(0, MEM_BYTES + 6) - 3 - ptr_off[k]);
            offer(itype(pick_mem_op(), 5'(PTR_FIRST + k), rt, imm), $urandom());
            left--;
         end else if (sel < 80) begin
            offer(itype(pick_alu_op(), rs, rt, imm), $urandom());
            left--;
         end else if (sel < 92) begin
            if ($urandom_range(0, 1) == 1) rt = rs;
            offer(itype(($urandom_range(0, 1) == 1) ? OP_BEQ : OP_BNE, rs, rt, imm),
                  $urandom());
            left--;
         end else begin
            offer($urandom(), $urandom());
            left--;
         end
      end
   endtask

   // receiver: short random stalls, plus two long hold-offs (after the 100th
   // and 600th response) so the pipe fills and back-pressures the sender
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_seen <= rsp_seen + 1;
         if (rsp_valid && rsp_ready && (rsp_seen == 99 || rsp_seen == 599)) begin
            rsp_ready  <= 1'b0;
            stall_left <= LONG_HOLD;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= (stall_left == 1);
         end else if (!no_idling && $urandom_range(0, 15) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(1, 18);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("mips_itype_execute regression: fail");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: ADDI limits and both overflow directions
      offer(itype(OP_ADDI,  R_ZERO, R_POS, 16'h7FFF), $urandom());
      offer(itype(OP_LUI,   R_ZERO, R_MAX, 16'h7FFF), $urandom());
      offer(itype(OP_ORI,   R_MAX,  R_MAX, 16'hFFFF), $urandom());
      offer(itype(OP_ADDI,  R_MAX,  R_OVF, 16'h0001), $urandom());
      offer(itype(OP_ADDI,  R_ZERO, R_NEG, 16'h8000), $urandom());
      offer(itype(OP_LUI,   R_ZERO, R_MIN, 16'h8000), $urandom());
      offer(itype(OP_ADDI,  R_MIN,  R_OVF, 16'hFFFF), $urandom());
      offer(itype(OP_ADDIU, R_MIN,  R_SUM, 16'hFFFF), $urandom());
      // write to register zero: value shown, nothing written
      offer(itype(OP_ADDIU, R_POS,  R_ZERO, 16'h0005), $urandom());
      // zero-extended logic immediates, signed compare both ways
      offer(itype(OP_ANDI,  R_NEG,  R_AND, 16'hFFFF), $urandom());
      offer(itype(OP_XORI,  R_NEG,  R_XOR, 16'hFFFF), $urandom());
      offer(itype(OP_SLTI,  R_MIN,  R_SLT, 16'h8000), $urandom());
      offer(itype(OP_SLTI,  R_MAX,  R_SLT, 16'h7FFF), $urandom());
      // branches: taken backwards, not taken, taken with pc wrap-around
      offer(itype(OP_BEQ,   R_ZERO, R_ZERO, 16'hFFFC), 32'h0040_0010);
      offer(itype(OP_BNE,   R_POS,  R_POS,  16'h0005), 32'h0000_0000);
      offer(itype(OP_BNE,   R_POS,  R_MAX,  16'h7FFF), 32'hFFFF_FFF0);
      // memory: sign-extending byte/half loads, unaligned half, window edges
      offer(itype(OP_LUI,   R_ZERO, R_PTR, DATA_BASE_RESET[31:16]), $urandom());
      offer(itype(OP_SW,    R_PTR,  R_XOR, 16'h0000), $urandom());
      offer(itype(OP_LB,    R_PTR,  R_LB,  16'h0001), $urandom());
      offer(itype(OP_LB,    R_PTR,  R_LB,  16'h0003), $urandom());
      offer(itype(OP_LH,    R_PTR,  R_LH,  16'h0001), $urandom());
      offer(itype(OP_SH,    R_PTR,  R_NEG, 16'(MEM_BYTES - 2)), $urandom());
      offer(itype(OP_SW,    R_PTR,  R_NEG, 16'(MEM_BYTES - 3)), $urandom());
      offer(itype(OP_LW,    R_PTR,  R_LW,  16'hFFFF), $urandom());
      offer(itype(OP_SB,    R_PTR,  R_POS, 16'(MEM_BYTES - 1)), $urandom());
      offer(itype(OP_LW,    R_PTR,  R_LW,  16'(MEM_BYTES - 4)), $urandom());
      // unsupported opcodes, all ones and all zeros
      offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(32'h0000_0000, 32'h0000_0000);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_base(phase_base(ph));
         if (ph == NUM_PHASES - 1) no_idling <= 1'b1;
         random_phase(RANDOM_PER_PHASE);
      end

      // drain, then a short settle for anything spurious
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("mips_itype_execute regression: pass");
      else
         $display("mips_itype_execute regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/mie_pkg.sv
rtl/core/mie_regfile.sv
rtl/core/mie_dmem.sv
rtl/core/mips_itype_execute.sv
sim/itype_result_checker.sv
sim/mips_itype_execute_test.sv
